### hdl/asp_pkg.sv
// Shared types and constants for the attached sprite pair allocator.
package asp_pkg;

   // Screen and sprite geometry.
   localparam int unsigned SCREEN_W      = 320;
   localparam int unsigned SCREEN_H      = 256;
   localparam int unsigned SPRITE_LINES  = 16;
   localparam int unsigned ROW_GAP       = 17;
   localparam int unsigned MAX_START_ROW = 213;

   // Display window offsets for the hardware position words.
   localparam logic [9:0] H_BASE = 10'h081;
   localparam logic [9:0] V_BASE = 10'h02c;

   // Entry count and cell index width; covers every legal table size.
   localparam int unsigned CNT_W = 6;

   // Command codes carried on the request side.
   localparam logic CMD_CLEAR = 1'b0;
   localparam logic CMD_ADD   = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // Request broadcast to every cell during a walk.
   typedef struct packed {
      logic [7:0] row;
      logic [7:0] palette;
   } probe_type;

   // Entry write broadcast to every cell.
   typedef struct packed {
      logic             en;
      logic [CNT_W-1:0] index;
      logic [7:0]       row;
      logic [7:0]       palette;
   } write_type;

   // Commands to the pair table.
   typedef struct packed {
      logic clear;
      logic take;
   } pair_cmd_type;

   // First free pair found for the current row.
   typedef struct packed {
      logic       found;
      logic [1:0] pair;
      logic [3:0] slot;
   } pair_pick_type;

endpackage

### hdl/asp_cell.sv
// One frame table entry with its overlap comparator, linked into the walk chain.
module asp_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  asp_pkg::probe_type       probe,
   input  logic [asp_pkg::CNT_W-1:0] count,
   input  asp_pkg::write_type       wr,
   input  logic                     token_in,
   input  logic                     flag_in,
   output logic                     token_out,
   output logic                     flag_out
);

   logic [7:0] row_ff;
   logic [7:0] palette_ff;
   logic       token_ff;
   logic       flag_ff;
   logic       active;
   logic       overlap;
   logic       hit;

   // Stored entry, written when the table appends at this index.
   always_ff @(posedge clock) begin
      if (wr.en && wr.index == asp_pkg::CNT_W'(INDEX)) begin
         row_ff     <= wr.row;
         palette_ff <= wr.palette;
      end
   end

   // A conflict is a live entry of another palette within one sprite height.
   always_comb begin
      active  = count > asp_pkg::CNT_W'(INDEX);
      overlap = ({1'b0, probe.row} < {1'b0, row_ff} + 9'(asp_pkg::SPRITE_LINES))
             && ({1'b0, row_ff} < {1'b0, probe.row} + 9'(asp_pkg::SPRITE_LINES));
      hit     = active && overlap && (palette_ff != probe.palette);
   end

   // The walk token and the running conflict flag move one cell per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         token_ff <= token_in;
         flag_ff  <= flag_in | (token_in & hit);
      end
   end

   assign token_out = token_ff;
   assign flag_out  = flag_ff;

endmodule

### hdl/asp_pairs.sv
// Per-pair slot counts and next free rows, with first-fit pair selection.
module asp_pairs #(
   parameter int unsigned NUM_PAIRS      = 4,
   parameter int unsigned SLOTS_PER_PAIR = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            row,
   input  asp_pkg::pair_cmd_type cmd,
   output asp_pkg::pair_pick_type pick
);

   logic [3:0] slots_ff [NUM_PAIRS];
   logic [7:0] next_row_ff [NUM_PAIRS];

   // Lowest numbered pair that is free at this row and has a slot left.
   always_comb begin
      pick = '0;
      for (int p = NUM_PAIRS - 1; p >= 0; p--) begin
         if (row >= next_row_ff[p] && slots_ff[p] < 4'(SLOTS_PER_PAIR)) begin
            pick.found = 1'b1;
            pick.pair  = 2'(p);
            pick.slot  = slots_ff[p];
         end
      end
   end

   // Clear restores every pair; a take books the chosen pair.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int p = 0; p < NUM_PAIRS; p++) begin
            slots_ff[p]    <= '0;
            next_row_ff[p] <= '0;
         end
      end else if (cmd.take) begin
         for (int p = 0; p < NUM_PAIRS; p++) begin
            if (pick.pair == 2'(p)) begin
               slots_ff[p]    <= slots_ff[p] + 4'd1;
               next_row_ff[p] <= row + 8'(asp_pkg::ROW_GAP);
            end
         end
      end
   end

endmodule

### hdl/attached_sprite_pair_allocator.sv
// Top level of the attached sprite pair allocator: sequencer, entry chain and result register.
//
//   channel  direction  tvalid/tready  payload
//   req      in         req_*          tuser command, tdata pos_x / pos_y / palette_id
//   rsp      out        rsp_*          tuser accepted, tdata pair / slot / entry / words
//
// An add that passes the screen and table checks sends a token down the chain of entry
// cells, one cell a cycle, before the result is decided.
// A clear, or an add rejected by the screen or table checks, skips the walk.
// A new item is taken while the previous result still waits in the output register;
// a finished result holds the block until that register is free.
// Reset is synchronous and empties the table; entry contents need no clearing.
module attached_sprite_pair_allocator #(
   parameter int unsigned NUM_PAIRS      = 4,
   parameter int unsigned SLOTS_PER_PAIR = 8,
   parameter int unsigned SPRITE_WIDTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pos_x[9:0], pos_y[19:10], palette_id[27:20], zeros
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pair_index[1:0], slot_in_pair[4:2], entry_index[9:5],
                                    // position_word[25:10], control_word[41:26], zeros
   output logic        rsp_tuser    // accepted
);

   localparam int unsigned MAX_ENTRIES = NUM_PAIRS * SLOTS_PER_PAIR;
   localparam int unsigned CW          = asp_pkg::CNT_W;

   asp_pkg::state_type     state_ff, state_in;
   logic                   cmd_ff;
   logic [9:0]             x_ff;
   logic [9:0]             y_ff;
   logic [7:0]             pal_ff;
   logic                   prefail_ff;
   logic                   conflict_ff;
   logic                   launch_ff;
   logic [CW-1:0]          count_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_accepted_ff;
   logic [1:0]             rsp_pair_ff;
   logic [2:0]             rsp_slot_ff;
   logic [4:0]             rsp_entry_ff;
   logic [15:0]            rsp_pos_ff;
   logic [15:0]            rsp_ctl_ff;

   logic                   accept;
   logic                   out_load;
   logic                   prefail;
   logic                   add_ok;
   logic [9:0]             in_x;
   logic [9:0]             in_y;
   logic [9:0]             vstart;
   logic [9:0]             vstop;
   logic [9:0]             hstart;
   logic [MAX_ENTRIES:0]   chain_token;
   logic [MAX_ENTRIES:0]   chain_flag;
   asp_pkg::probe_type     probe;
   asp_pkg::write_type     wr;
   asp_pkg::pair_cmd_type  pair_cmd;
   asp_pkg::pair_pick_type pick;

   // Screen, start row and table checks on the incoming add.
   always_comb begin
      in_x    = req_tdata[9:0];
      in_y    = req_tdata[19:10];
      prefail = in_x[9] || in_y[9]
             || (in_x > 10'(asp_pkg::SCREEN_W - SPRITE_WIDTH))
             || (in_y > 10'(asp_pkg::SCREEN_H - asp_pkg::SPRITE_LINES))
             || (in_y > 10'(asp_pkg::MAX_START_ROW))
             || (count_ff >= CW'(MAX_ENTRIES));
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         asp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == asp_pkg::CMD_ADD && !prefail) ?
                          asp_pkg::ST_WALK : asp_pkg::ST_DONE;
            end
         end
         asp_pkg::ST_WALK: begin
            if (chain_token[MAX_ENTRIES]) begin
               state_in = asp_pkg::ST_DONE;
            end
         end
         asp_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = asp_pkg::ST_IDLE;
            end
         end
         default: state_in = asp_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         asp_pkg::ST_IDLE: req_tready = 1'b1;
         asp_pkg::ST_WALK: ;
         asp_pkg::ST_DONE: out_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request hold register and walk launch.
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff   <= 1'b0;
         conflict_ff <= 1'b0;
      end else begin
         launch_ff <= accept && req_tuser == asp_pkg::CMD_ADD && !prefail;
         if (accept) begin
            conflict_ff <= 1'b0;
         end else if (state_ff == asp_pkg::ST_WALK && chain_token[MAX_ENTRIES]) begin
            conflict_ff <= chain_flag[MAX_ENTRIES];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_tuser;
         x_ff       <= in_x;
         y_ff       <= in_y;
         pal_ff     <= req_tdata[27:20];
         prefail_ff <= prefail;
      end
   end

   // Chain of entry cells; the token enters at cell zero.
   assign probe.row      = y_ff[7:0];
   assign probe.palette  = pal_ff;
   assign chain_token[0] = launch_ff;
   assign chain_flag[0]  = 1'b0;

   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      asp_cell #(
         .INDEX(k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .probe    (probe),
         .count    (count_ff),
         .wr       (wr),
         .token_in (chain_token[k]),
         .flag_in  (chain_flag[k]),
         .token_out(chain_token[k+1]),
         .flag_out (chain_flag[k+1])
      );
   end

   // Pair table.
   asp_pairs #(
      .NUM_PAIRS     (NUM_PAIRS),
      .SLOTS_PER_PAIR(SLOTS_PER_PAIR)
   ) u_pairs (
      .clock(clock),
      .reset(reset),
      .row  (y_ff[7:0]),
      .cmd  (pair_cmd),
      .pick (pick)
   );

   // Final decision and the state updates that commit it.
   always_comb begin
      add_ok         = cmd_ff == asp_pkg::CMD_ADD && !prefail_ff && !conflict_ff
                    && pick.found;
      pair_cmd.clear = out_load && cmd_ff == asp_pkg::CMD_CLEAR;
      pair_cmd.take  = out_load && add_ok;
      wr.en          = out_load && add_ok;
      wr.index       = count_ff;
      wr.row         = y_ff[7:0];
      wr.palette     = pal_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || pair_cmd.clear) begin
         count_ff <= '0;
      end else if (wr.en) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // Hardware position and control words.
   always_comb begin
      vstart = asp_pkg::V_BASE + y_ff;
      vstop  = vstart + 10'(asp_pkg::SPRITE_LINES);
      hstart = asp_pkg::H_BASE + x_ff;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_accepted_ff <= add_ok;
         rsp_pair_ff     <= add_ok ? pick.pair : 2'd0;
         rsp_slot_ff     <= add_ok ? pick.slot[2:0] : 3'd0;
         rsp_entry_ff    <= add_ok ? count_ff[4:0] : 5'd0;
         rsp_pos_ff      <= add_ok ? {vstart[7:0], hstart[8:1]} : 16'd0;
         rsp_ctl_ff      <= add_ok ? {vstop[7:0], 5'd0, vstart[8], vstop[8], hstart[0]}
                                   : 16'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_accepted_ff;
   assign rsp_tdata  = {6'd0, rsp_ctl_ff, rsp_pos_ff, rsp_entry_ff, rsp_slot_ff, rsp_pair_ff};

`ifndef SYNTHESIS
   // The walk token only leaves the chain while the sequencer waits for it.
   a_token_in_walk: assert property (@(posedge clock) disable iff (reset)
      chain_token[MAX_ENTRIES] |-> state_ff == asp_pkg::ST_WALK)
      else $error("walk token left the chain outside a walk");

   // The table never holds more entries than it has cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   // The probe stays put for the whole walk.
   a_probe_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == asp_pkg::ST_WALK && $past(state_ff) == asp_pkg::ST_WALK)
      |-> $stable(probe))
      else $error("probe changed during a walk");

   // An accepted result always books an entry in the table.
   a_accept_books: assert property (@(posedge clock) disable iff (reset)
      (out_load && add_ok) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted sprite not entered in the table");
`endif

endmodule
